FILE: hw/rtl/nus_pkg.sv
package nus_pkg;

  localparam int PIX_W   = 8;
  localparam int SCALE_W = 4;
  localparam int WIDTH_W = 9;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 1;
  localparam int COL_W   = 11;

  localparam logic [IDX_W-1:0] REG_SCALE    = 1'b0;
  localparam logic [IDX_W-1:0] REG_IN_WIDTH = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [1:0] {
    JOB_PIXEL,
    JOB_TICK,
    JOB_REJECT
  } job_kind_e;

  typedef struct packed {
    logic                    action;
    logic signed [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] out_value;
    logic                    row_end;
    logic                    run_end;
    logic                    rejected;
  } out_item_t;

  typedef struct packed {
    job_kind_e               kind;
    logic signed [PIX_W-1:0] value;
    logic                    row_end;
  } job_t;

endpackage

FILE: hw/rtl/nus_ram.sv
module nus_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nus_div.sv
module nus_div #(
  parameter int DivW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nus_pkg::COL_W-1:0] dividend_i,
  input  logic [DivW-1:0]           divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [nus_pkg::COL_W-1:0] quot_o,
  output logic [DivW-1:0]           rem_o
);

  localparam int XW   = nus_pkg::COL_W;
  localparam int CntW = $clog2(XW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [XW-1:0]   quo_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] dvs_q;
  logic [DivW:0]   trial;
  logic            ge;
  logic [DivW-1:0] rem_nx;

  assign trial  = {rem_q, quo_q[XW-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign rem_nx = ge ? DivW'(trial - {1'b0, dvs_q}) : DivW'(trial);

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = {quo_q[XW-2:0], ge};
  assign rem_o  = rem_nx;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(XW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[XW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero step count");

endmodule

FILE: hw/rtl/nus_emit.sv
module nus_emit #(
  parameter int CntW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_load_i,
  input  nus_pkg::job_t             job_i,
  input  logic [CntW-1:0]           count_i,
  input  logic [nus_pkg::PIX_W-1:0] rdata_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output nus_pkg::out_item_t        out_data_o
);

  logic               job_valid_q, job_valid_d;
  nus_pkg::job_t      job_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  nus_pkg::out_item_t out_q, out_d;
  logic               load_out;
  logic               last;

  assign load_out = job_valid_q && (!out_valid_q || out_ready_i);
  assign last     = cnt_q == CntW'(1);
  assign free_o   = !job_valid_q || (load_out && last);

  always_comb begin
    out_d          = out_q;
    out_d.row_end  = last && job_q.row_end;
    out_d.run_end  = last;
    out_d.rejected = 1'b0;
    case (job_q.kind)
      nus_pkg::JOB_PIXEL: begin
        out_d.out_value = job_q.value;
      end
      nus_pkg::JOB_TICK: begin
        out_d.out_value = $signed(rdata_i);
      end
      nus_pkg::JOB_REJECT: begin
        out_d.out_value = '0;
        out_d.row_end   = 1'b0;
        out_d.rejected  = 1'b1;
      end
      default: begin
        out_d.out_value = '0;
      end
    endcase
  end

  always_comb begin
    job_valid_d = job_valid_q;
    cnt_d       = cnt_q;
    if (load_out) begin
      cnt_d = cnt_q - CntW'(1);
      if (last) begin
        job_valid_d = 1'b0;
      end
    end
    if (job_load_i) begin
      job_valid_d = 1'b1;
      cnt_d       = count_i;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> cnt_q != '0)
    else $error("pending request with no results left");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> free_o)
    else $error("request loaded over an unfinished one");

endmodule

FILE: hw/rtl/nearest_upsample_row_replicate_core.sv
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_ready_o  | in_data_i   (action, pixel_value)
// out     | out | out_valid_o / out_ready_i| out_data_o  (out_value, row_end, run_end, rejected)
// cfg     | in  | cfg_we_i, no wait        | cfg_idx_i, cfg_wdata_i
//
// A tick or a rejected pixel yields one result, a pixel yields scale results and an ignored
// request none; one result per cycle through the result register while out_ready_i is high.
// From accept, a request passes the request register and then the result register to the output.
// A write of a nonzero scale re-derives the replay position in a radix-2 divider: in_ready_o
// stays low from the write until the divider is done.
// Reset clears control state only; the line buffer holds no reset value.
// A stalled result register stalls the request register and then in_ready_o.
module nearest_upsample_row_replicate_core #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_SCALE = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  nus_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output nus_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [nus_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [nus_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int XW = nus_pkg::COL_W;
  localparam int LW = WW + SW;

  function automatic logic [SW-1:0] eff_scale(input logic [nus_pkg::SCALE_W-1:0] v);
    if (32'(v) > MAX_SCALE) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = SW'(v);
    end
  endfunction

  logic [nus_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [nus_pkg::WIDTH_W-1:0] width_q, width_d;
  logic [CW-1:0]               src_col_q, src_col_d;
  logic [RW-1:0]               rep_row_q, rep_row_d;
  logic [XW-1:0]               rep_col_q, rep_col_d;
  logic [XW-1:0]               rep_idx_q, rep_idx_d;
  logic [SW-1:0]               rep_ph_q, rep_ph_d;
  logic                        pending_q, pending_d;

  logic [SW-1:0] s;
  logic [WW-1:0] w;
  logic [LW-1:0] row_len;
  logic          accept;
  logic          last_col;
  logic          end_row;
  logic [RW:0]   row_inc;
  logic [XW-1:0] col_inc;
  logic [CW-1:0] rd_addr;
  logic          scale_wr;
  logic [SW-1:0] new_s;

  logic          ram_we;
  logic          ram_re;
  logic [nus_pkg::PIX_W-1:0] ram_rdata;

  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [XW-1:0] div_quot;
  logic [SW-1:0] div_rem;

  logic          job_load;
  nus_pkg::job_t job;
  logic [SW-1:0] job_count;
  logic          emit_free;

  assign s = eff_scale(scale_q);

  always_comb begin
    if (width_q == '0) begin
      w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_q);
    end
  end

  assign row_len  = LW'(w) * LW'(s);
  assign last_col = (32'(src_col_q) + 32'd1) >= 32'(w);
  assign end_row  = (32'(rep_col_q) + 32'd1) >= 32'(row_len);
  assign row_inc  = (RW + 1)'(rep_row_q) + (RW + 1)'(1);
  assign col_inc  = rep_col_q + XW'(1);
  assign rd_addr  = (32'(rep_idx_q) >= MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(rep_idx_q);

  assign scale_wr  = cfg_we_i && (cfg_idx_i == nus_pkg::REG_SCALE);
  assign new_s     = eff_scale(cfg_wdata_i[nus_pkg::SCALE_W-1:0]);
  assign div_start = scale_wr && (new_s != '0);

  assign in_ready_o = emit_free && !div_busy && !scale_wr;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    scale_d   = scale_q;
    width_d   = width_q;
    src_col_d = src_col_q;
    rep_row_d = rep_row_q;
    rep_col_d = rep_col_q;
    rep_idx_d = rep_idx_q;
    rep_ph_d  = rep_ph_q;
    pending_d = pending_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    job_load  = 1'b0;
    job       = '{kind: nus_pkg::JOB_PIXEL, value: in_data_i.pixel_value, row_end: 1'b0};
    job_count = SW'(1);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        nus_pkg::REG_SCALE:    scale_d = cfg_wdata_i[nus_pkg::SCALE_W-1:0];
        nus_pkg::REG_IN_WIDTH: width_d = cfg_wdata_i[nus_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end

    if (div_done) begin
      rep_idx_d = div_quot;
      rep_ph_d  = div_rem;
    end

    if (accept && (s != '0)) begin
      if (in_data_i.action == nus_pkg::ACT_PIXEL) begin
        job_load = 1'b1;
        if (pending_q) begin
          job.kind = nus_pkg::JOB_REJECT;
        end else begin
          ram_we      = 1'b1;
          job.row_end = last_col;
          job_count   = s;
          if (last_col) begin
            src_col_d = '0;
            if (s != SW'(1)) begin
              pending_d = 1'b1;
              rep_row_d = RW'(1);
              rep_col_d = '0;
              rep_idx_d = '0;
              rep_ph_d  = '0;
            end
          end else begin
            src_col_d = src_col_q + CW'(1);
          end
        end
      end else if (pending_q) begin
        job_load    = 1'b1;
        ram_re      = 1'b1;
        job.kind    = nus_pkg::JOB_TICK;
        job.row_end = end_row;
        if (end_row) begin
          rep_col_d = '0;
          rep_idx_d = '0;
          rep_ph_d  = '0;
          if (32'(row_inc) >= 32'(s)) begin
            pending_d = 1'b0;
            rep_row_d = '0;
          end else begin
            rep_row_d = RW'(row_inc);
          end
        end else begin
          rep_col_d = col_inc;
          if (col_inc == '0) begin
            rep_idx_d = '0;
            rep_ph_d  = '0;
          end else if ((32'(rep_ph_q) + 32'd1) == 32'(s)) begin
            rep_idx_d = rep_idx_q + XW'(1);
            rep_ph_d  = '0;
          end else begin
            rep_ph_d = rep_ph_q + SW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= nus_pkg::SCALE_W'(1);
      width_q   <= nus_pkg::WIDTH_W'(1);
      src_col_q <= '0;
      rep_row_q <= '0;
      rep_col_q <= '0;
      rep_idx_q <= '0;
      rep_ph_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      scale_q   <= scale_d;
      width_q   <= width_d;
      src_col_q <= src_col_d;
      rep_row_q <= rep_row_d;
      rep_col_q <= rep_col_d;
      rep_idx_q <= rep_idx_d;
      rep_ph_q  <= rep_ph_d;
      pending_q <= pending_d;
    end
  end

  nus_ram #(
    .Width (nus_pkg::PIX_W),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (src_col_q),
    .wdata_i (in_data_i.pixel_value),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  nus_div #(
    .DivW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rep_col_q),
    .divisor_i  (new_s),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  nus_emit #(
    .CntW (SW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_load_i  (job_load),
    .job_i       (job),
    .count_i     (job_count),
    .rdata_i     (ram_rdata),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_div_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_ready_o)
    else $error("request taken while replay position is re-derived");

  a_pending_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> rep_row_q != '0)
    else $error("replay pending on the source row");

endmodule

FILE: test/upsample_row_checker.sv
module upsample_row_checker
  import nus_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_SCALE = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  in_item_t            req_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  out_item_t           res_i,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIX_W-1:0]   line_buf [MAX_WIDTH];
  int unsigned        src_col;
  int unsigned        rep_row;
  int unsigned        rep_col;
  bit                 rep_busy;
  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_r;
  out_item_t          due_pixels [$];
  int                 errors;

  function automatic out_item_t pack_result(logic [PIX_W-1:0] v, logic re, logic ru,
                                            logic rj);
    out_item_t r;
    r.out_value = v;
    r.row_end   = re;
    r.run_end   = ru;
    r.rejected  = rj;
    return r;
  endfunction

  task automatic replicate_request(input in_item_t rq);
    int unsigned s;
    int unsigned w;
    int unsigned i;
    int unsigned idx;
    int unsigned row_len;
    bit          last_col;
    bit          end_row;
    s = (scale_r > MAX_SCALE) ? MAX_SCALE : scale_r;
    w = (width_r == 0) ? 1 : ((width_r > MAX_WIDTH) ? MAX_WIDTH : width_r);
    if (s == 0) return;
    if (rq.action == ACT_PIXEL) begin
      if (rep_busy) begin
        due_pixels.push_back(pack_result('0, 1'b0, 1'b1, 1'b1));
        return;
      end
      if (src_col >= MAX_WIDTH) src_col = MAX_WIDTH - 1;
      line_buf[src_col] = rq.pixel_value;
      last_col = (src_col + 1 >= w);
      for (i = 0; i < s; i++) begin
        due_pixels.push_back(pack_result(rq.pixel_value, last_col && (i + 1 == s),
                                         i + 1 == s, 1'b0));
      end
      if (last_col) begin
        src_col = 0;
        if (s > 1) begin
          rep_busy = 1'b1;
          rep_row  = 1;
          rep_col  = 0;
        end
      end else begin
        src_col++;
      end
      return;
    end
    if (!rep_busy) return;
    row_len = w * s;
    idx     = rep_col / s;
    end_row = (rep_col + 1 >= row_len);
    if (idx >= MAX_WIDTH) idx = MAX_WIDTH - 1;
    due_pixels.push_back(pack_result(line_buf[idx], end_row, 1'b1, 1'b0));
    if (end_row) begin
      rep_col = 0;
      rep_row++;
      if (rep_row >= s) begin
        rep_busy = 1'b0;
        rep_row  = 0;
      end
    end else begin
      rep_col = (rep_col + 1) & 32'h7FF;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      src_col  = 0;
      rep_row  = 0;
      rep_col  = 0;
      rep_busy = 1'b0;
      scale_r  = 1;
      width_r  = 1;
      errors   = 0;
      due_pixels.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SCALE) scale_r = cfg_wdata_i[SCALE_W-1:0];
        else if (cfg_idx_i == REG_IN_WIDTH) width_r = cfg_wdata_i[WIDTH_W-1:0];
      end
      if (req_valid_i && req_ready_i) replicate_request(req_i);
      if (res_valid_i && res_ready_i) begin
        if (due_pixels.size() == 0) begin
          $error("unexpected result: out_value %0d row_end %0b run_end %0b rejected %0b",
                 res_i.out_value, res_i.row_end, res_i.run_end, res_i.rejected);
          errors++;
        end else begin
          want = due_pixels.pop_front();
          if (res_i.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, res_i.out_value);
            errors++;
          end
          if (res_i.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, res_i.row_end);
            errors++;
          end
          if (res_i.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, res_i.run_end);
            errors++;
          end
          if (res_i.rejected !== want.rejected) begin
            $error("rejected: expected %0b, got %0b", want.rejected, res_i.rejected);
            errors++;
          end
        end
      end
      pending_o    <= due_pixels.size();
      fail_count_o <= errors;
    end
  end

endmodule

FILE: test/tb_nearest_upsample_row_replicate_core.sv
module tb_nearest_upsample_row_replicate_core;
  timeunit 1ns;
  timeprecision 1ps;
  import nus_pkg::*;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_SCALE   = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int WORK_ITEMS  = 310;
  localparam int FILL_ITEMS  = 32;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_item_t        out_data_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int               pending_n;
  int               fail_n;
  bit               quiet;
  bit               hold_go;
  bit               hold_seen;
  int unsigned      work_n;

  always #10 clk_i = ~clk_i;

  nearest_upsample_row_replicate_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  upsample_row_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_ready_i  (in_ready_o),
    .req_i        (in_data_i),
    .res_valid_i  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_i        (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending_n),
    .fail_count_o (fail_n)
  );

  initial begin
    out_ready_i <= 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_req(input logic act, input logic [PIX_W-1:0] val);
    in_item_t rq;
    rq.action      = act;
    rq.pixel_value = val;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    work_n++;
    if (work_n >= WORK_ITEMS - 60) quiet <= 1'b1;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input int unsigned sc, input int unsigned wd);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SCALE;
    cfg_wdata_i <= CFG_W'(sc);
    @(posedge clk_i);
    cfg_idx_i   <= REG_IN_WIDTH;
    cfg_wdata_i <= CFG_W'(wd);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_segment();
    int unsigned sc;
    int unsigned wd;
    int unsigned eff_s;
    int unsigned eff_w;
    int unsigned pick;
    int unsigned rows;
    int unsigned cap;
    int unsigned sent;
    int unsigned r;
    int unsigned c;
    pick = $urandom_range(0, 19);
    if (pick == 0) sc = 0;
    else if (pick < 5) sc = 1;
    else if (pick < 12) sc = 2;
    else if (pick < 17) sc = 3;
    else sc = $urandom_range(4, 15);
    rows = (sc >= 4) ? 1 : $urandom_range(1, 3);
    cap  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 100000;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      wd = 0;
    end else if (pick == 1) begin
      wd  = $urandom_range(100, 511);
      sc  = (sc > 1) ? 1 : sc;
      cap = $urandom_range(1, 40);
    end else begin
      wd = (sc >= 4) ? $urandom_range(1, 2) : $urandom_range(1, 5);
    end
    set_mode(sc, wd);
    eff_s = (sc > MAX_SCALE) ? MAX_SCALE : sc;
    eff_w = (wd == 0) ? 1 : ((wd > MAX_WIDTH) ? MAX_WIDTH : wd);
    sent  = 0;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < eff_w; c++) begin
        if (sent >= cap || work_n >= WORK_ITEMS) return;
        send_req(ACT_PIXEL, PIX_W'($urandom));
        sent++;
      end
      if (eff_s > 1) begin
        for (c = 0; c < (eff_s - 1) * eff_w * eff_s; c++) begin
          if (sent >= cap || work_n >= WORK_ITEMS) return;
          if ($urandom_range(0, 19) == 0) begin
            send_req(ACT_PIXEL, PIX_W'($urandom));
          end
          send_req(ACT_TICK, PIX_W'($urandom));
          sent++;
        end
      end
      if (work_n >= WORK_ITEMS) return;
      if ($urandom_range(0, 7) == 0) send_req(ACT_TICK, PIX_W'($urandom));
    end
  endtask

  initial begin
    int unsigned k;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_SCALE;
    cfg_wdata_i <= '0;
    quiet       <= 1'b0;
    hold_go     <= 1'b0;
    work_n       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(ACT_PIXEL, 8'h80);
    send_req(ACT_PIXEL, 8'h7F);
    send_req(ACT_TICK, 8'h00);
    send_req(ACT_PIXEL, 8'h00);

    set_mode(1, 511);
    for (k = 0; k < FILL_ITEMS; k++) send_req(ACT_PIXEL, PIX_W'($urandom));

    set_mode(3, 1);
    send_req(ACT_PIXEL, 8'h55);
    send_req(ACT_PIXEL, 8'hAA);
    for (k = 0; k < 6; k++) send_req(ACT_TICK, 8'hFF);
    send_req(ACT_TICK, 8'h00);

    set_mode(0, 4);
    send_req(ACT_PIXEL, 8'h12);
    send_req(ACT_TICK, 8'h34);

    set_mode(15, 0);
    send_req(ACT_PIXEL, 8'hC3);
    for (k = 0; k < 8; k++) send_req(ACT_TICK, 8'h00);
    set_mode(2, 0);
    send_req(ACT_TICK, 8'h00);
    send_req(ACT_TICK, 8'h00);

    set_mode(4, 3);
    hold_go <= ~hold_go;
    for (k = 0; k < 3; k++) send_req(ACT_PIXEL, PIX_W'($urandom));
    for (k = 0; k < 36; k++) send_req(ACT_TICK, PIX_W'($urandom));
    drain();

    while (work_n < WORK_ITEMS) begin
      run_segment();
    end

    drain();
    if (fail_n == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/nus_pkg.sv
hw/rtl/nus_ram.sv
hw/rtl/nus_div.sv
hw/rtl/nus_emit.sv
hw/rtl/nearest_upsample_row_replicate_core.sv
test/upsample_row_checker.sv
test/tb_nearest_upsample_row_replicate_core.sv
